/* rtl/dflbd_pkg.sv */
// ----------------------------------------------------------------------------
// dflbd_pkg
// Shared types, constants and exp tables for the DFL box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dflbd_pkg;

    // Bins per cell and grid size limit
    localparam int BINS     = 16;
    localparam int GRID_MAX = 256;

    // Divider: numerator width and iteration counter width
    localparam int NUM_W = 51;
    localparam int CNT_W = $clog2(NUM_W);

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 22;

    localparam logic [CFG_IDX_W-1:0] CFG_CONF_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_STRIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_LEFT       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TOP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_X        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO_Y        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd7;

    // Shared multiplier operations
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_EXP1L = 4'd1;   // EI[31:0]  * EH
    localparam t_op OP_EXP1H = 4'd2;   // EI[34:32] * EH << 32
    localparam t_op OP_EXP2L = 4'd3;   // T[31:0]   * EL
    localparam t_op OP_EXP2H = 4'd4;   // T[35:32]  * EL << 32
    localparam t_op OP_WSL   = 4'd5;   // W[31:0]   * stride
    localparam t_op OP_WSH   = 4'd6;   // W[35:32]  * stride << 32
    localparam t_op OP_EDL   = 4'd7;   // diff[31:0]  * ratio
    localparam t_op OP_EDH   = 4'd8;   // diff[63:32] * ratio << 32

    // Controller to datapath commands
    typedef struct packed {
        logic       capture;
        t_op        mul_op;
        logic [1:0] side;
        logic       exp_class;
        logic       latch_tmp;
        logic       acc_sum;
        logic       div_conf;
        logic       div_dist;
        logic       div_step;
        logic       latch_conf;
        logic       make_diff;
        logic       store_edge;
        logic       load_out;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic bin_ok;
        logic bin_last;
        logic conf_pass;
    } t_status;

    // e^(n-8), Q.24
    function automatic logic [34:0] exp_int(input logic [3:0] n);
        logic [34:0] v;
        case (n)
            4'd0:  v = 35'd5628;
            4'd1:  v = 35'd15299;
            4'd2:  v = 35'd41587;
            4'd3:  v = 35'd113044;
            4'd4:  v = 35'd307285;
            4'd5:  v = 35'd835288;
            4'd6:  v = 35'd2270549;
            4'd7:  v = 35'd6171993;
            4'd8:  v = 35'd16777216;
            4'd9:  v = 35'd45605201;
            4'd10: v = 35'd123967790;
            4'd11: v = 35'd336979391;
            4'd12: v = 35'd916004956;
            4'd13: v = 35'd2489959628;
            4'd14: v = 35'd6768412009;
            default: v = 35'd18398451372;
        endcase
        return v;
    endfunction

    // e^(a/16), Q.16
    function automatic logic [17:0] exp_hi(input logic [3:0] a);
        logic [17:0] v;
        case (a)
            4'd0:  v = 18'd65536;
            4'd1:  v = 18'd69763;
            4'd2:  v = 18'd74262;
            4'd3:  v = 18'd79052;
            4'd4:  v = 18'd84150;
            4'd5:  v = 18'd89577;
            4'd6:  v = 18'd95354;
            4'd7:  v = 18'd101504;
            4'd8:  v = 18'd108051;
            4'd9:  v = 18'd115019;
            4'd10: v = 18'd122437;
            4'd11: v = 18'd130334;
            4'd12: v = 18'd138740;
            4'd13: v = 18'd147688;
            4'd14: v = 18'd157213;
            default: v = 18'd167352;
        endcase
        return v;
    endfunction

    // e^(b/256), Q.16
    function automatic logic [16:0] exp_lo(input logic [3:0] b);
        logic [16:0] v;
        case (b)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd65793;
            4'd2:  v = 17'd66050;
            4'd3:  v = 17'd66309;
            4'd4:  v = 17'd66568;
            4'd5:  v = 17'd66829;
            4'd6:  v = 17'd67090;
            4'd7:  v = 17'd67353;
            4'd8:  v = 17'd67616;
            4'd9:  v = 17'd67881;
            4'd10: v = 17'd68147;
            4'd11: v = 17'd68413;
            4'd12: v = 17'd68681;
            4'd13: v = 17'd68950;
            4'd14: v = 17'd69220;
            default: v = 17'd69491;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* rtl/dflbd_ctrl.sv */
// ----------------------------------------------------------------------------
// dflbd_ctrl
// Sequencer: steps the shared multiplier, divider and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dflbd_ctrl
    import dflbd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_stall,
    output logic         o_valid,
    input  wire logic    i_stall,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_EXP   = 4'd2;
    localparam logic [3:0] S_DIVC  = 4'd3;
    localparam logic [3:0] S_CONF  = 4'd4;
    localparam logic [3:0] S_SIDE  = 4'd5;
    localparam logic [3:0] S_DIVD  = 4'd6;
    localparam logic [3:0] S_EDGE  = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

    logic [3:0]       r_state, n_state;
    logic [2:0]       r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_side, n_side;
    logic             r_cls, n_cls;
    logic             r_out_valid, n_out_valid;
    t_cmd             cmd;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_cnt   = r_cnt;
        n_side  = r_side;
        n_cls   = r_cls;
        cmd     = '0;
        cmd.side      = r_side;
        cmd.exp_class = r_cls;
        cmd.mul_op    = OP_NONE;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                n_side = 2'd0;
                n_step = 3'd0;
                n_cls  = 1'b0;
                n_state = i_status.bin_ok ? S_EXP : S_IDLE;
            end
            S_EXP: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: cmd.mul_op = OP_EXP1L;
                    3'd1: cmd.mul_op = OP_EXP1H;
                    3'd2: cmd.latch_tmp = 1'b1;
                    3'd3: cmd.mul_op = OP_EXP2L;
                    3'd4: cmd.mul_op = OP_EXP2H;
                    default: begin
                        n_step = 3'd0;
                        if (r_cls) begin
                            cmd.div_conf = 1'b1;
                            n_cnt   = '0;
                            n_state = S_DIVC;
                        end else begin
                            cmd.acc_sum = 1'b1;
                            if (r_side == 2'd3) begin
                                if (i_status.bin_last) begin
                                    n_cls = 1'b1;
                                end else begin
                                    n_state = S_IDLE;
                                end
                            end else begin
                                n_side = r_side + 2'd1;
                            end
                        end
                    end
                endcase
            end
            S_DIVC: begin
                cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_CONF;
                end
            end
            S_CONF: begin
                cmd.latch_conf = 1'b1;
                n_side = 2'd0;
                n_step = 3'd0;
                n_state = i_status.conf_pass ? S_SIDE : S_IDLE;
            end
            S_SIDE: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: cmd.mul_op = OP_WSL;
                    3'd1: cmd.mul_op = OP_WSH;
                    default: begin
                        cmd.div_dist = 1'b1;
                        n_cnt   = '0;
                        n_step  = 3'd0;
                        n_state = S_DIVD;
                    end
                endcase
            end
            S_DIVD: begin
                cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                n_step = r_step + 3'd1;
                case (r_step)
                    3'd0: cmd.make_diff = 1'b1;
                    3'd1: cmd.mul_op = OP_EDL;
                    3'd2: cmd.mul_op = OP_EDH;
                    default: begin
                        cmd.store_edge = 1'b1;
                        n_step = 3'd0;
                        if (r_side == 2'd3) begin
                            n_state = S_OUT;
                        end else begin
                            n_side  = r_side + 2'd1;
                            n_state = S_SIDE;
                        end
                    end
                endcase
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, cleared when the transaction completes
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_side      <= '0;
            r_cls       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_side      <= n_side;
            r_cls       <= n_cls;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/dflbd_datapath.sv */
// ----------------------------------------------------------------------------
// dflbd_datapath
// Exp tables, bin sums, shared multiplier, divider, box build and registers.
// ----------------------------------------------------------------------------
`default_nettype none

module dflbd_datapath
    import dflbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cmd                 i_cmd,
    output t_status                   o_status,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic [7:0]           i_cell_row,
    input  wire logic [7:0]           i_cell_col,
    input  wire logic [3:0]           i_bin_index,
    input  wire logic signed [15:0]   i_class_logit,
    input  wire logic signed [15:0]   i_logit_left,
    input  wire logic signed [15:0]   i_logit_top,
    input  wire logic signed [15:0]   i_logit_right,
    input  wire logic signed [15:0]   i_logit_bottom,
    output logic [13:0]               o_box_x,
    output logic [13:0]               o_box_y,
    output logic [13:0]               o_box_width,
    output logic [13:0]               o_box_height,
    output logic [15:0]               o_confidence,
    output logic [7:0]                o_box_row,
    output logic [7:0]                o_box_col
);

    // Configuration registers
    logic [15:0] r_thr;
    logic [6:0]  r_stride;
    logic [9:0]  r_pad_left, r_pad_top;
    logic [21:0] r_ratio_x, r_ratio_y;
    logic [14:0] r_img_w, r_img_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= 16'd32768;
            r_stride   <= 7'd8;
            r_pad_left <= 10'd0;
            r_pad_top  <= 10'd0;
            r_ratio_x  <= 22'd65536;
            r_ratio_y  <= 22'd65536;
            r_img_w    <= 15'd640;
            r_img_h    <= 15'd640;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CONF_THRESHOLD: r_thr      <= i_cfg_data[15:0];
                CFG_GRID_STRIDE:    r_stride   <= i_cfg_data[6:0];
                CFG_PAD_LEFT:       r_pad_left <= i_cfg_data[9:0];
                CFG_PAD_TOP:        r_pad_top  <= i_cfg_data[9:0];
                CFG_RATIO_X:        r_ratio_x  <= i_cfg_data;
                CFG_RATIO_Y:        r_ratio_y  <= i_cfg_data;
                CFG_IMAGE_WIDTH:    r_img_w    <= i_cfg_data[14:0];
                default:            r_img_h    <= i_cfg_data[14:0];
            endcase
        end
    end

    // Captured item
    logic [7:0]         r_row, r_col;
    logic [3:0]         r_bin;
    logic signed [15:0] r_class;
    logic signed [15:0] r_logit [4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row      <= i_cell_row;
            r_col      <= i_cell_col;
            r_bin      <= i_bin_index;
            r_class    <= i_class_logit;
            r_logit[0] <= i_logit_left;
            r_logit[1] <= i_logit_top;
            r_logit[2] <= i_logit_right;
            r_logit[3] <= i_logit_bottom;
        end
    end

    assign o_status.bin_ok   = ({28'd0, r_bin} < 32'(BINS));
    assign o_status.bin_last = ({28'd0, r_bin} == 32'(BINS - 1));

    // Exp table index from the clamped Q8.8 logit
    logic signed [15:0] lg, lg_c;
    logic [11:0]        u;
    logic [34:0]        ei;
    logic [17:0]        eh;
    logic [16:0]        el;

    always_comb begin
        lg = i_cmd.exp_class ? r_class : r_logit[i_cmd.side];
        if (lg < -16'sd2048) begin
            lg_c = -16'sd2048;
        end else if (lg > 16'sd2047) begin
            lg_c = 16'sd2047;
        end else begin
            lg_c = lg;
        end
        u  = {~lg_c[11], lg_c[10:0]};
        ei = exp_int(u[11:8]);
        eh = exp_hi(u[7:4]);
        el = exp_lo(u[3:0]);
    end

    // Shared multiplier with 64-bit accumulator
    logic [63:0] r_acc;
    logic [35:0] r_tmp;
    logic [31:0] r_esum [4];
    logic [35:0] r_wsum [4];
    logic signed [63:0] r_diff;
    logic [31:0] mul_a;
    logic [21:0] mul_b;
    logic        mul_hi, mul_clr, mul_en;
    logic [53:0] prod;
    logic [63:0] acc_base, acc_add;
    logic [21:0] ratio_sel;

    assign ratio_sel = i_cmd.side[0] ? r_ratio_y : r_ratio_x;

    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_hi  = 1'b0;
        mul_clr = 1'b1;
        mul_en  = 1'b1;
        unique case (i_cmd.mul_op)
            OP_EXP1L: begin
                mul_a = ei[31:0];
                mul_b = {4'd0, eh};
            end
            OP_EXP1H: begin
                mul_a = {29'd0, ei[34:32]};
                mul_b = {4'd0, eh};
                mul_hi = 1'b1;
                mul_clr = 1'b0;
            end
            OP_EXP2L: begin
                mul_a = r_tmp[31:0];
                mul_b = {5'd0, el};
            end
            OP_EXP2H: begin
                mul_a = {28'd0, r_tmp[35:32]};
                mul_b = {5'd0, el};
                mul_hi = 1'b1;
                mul_clr = 1'b0;
            end
            OP_WSL: begin
                mul_a = r_wsum[i_cmd.side][31:0];
                mul_b = {15'd0, r_stride};
            end
            OP_WSH: begin
                mul_a = {28'd0, r_wsum[i_cmd.side][35:32]};
                mul_b = {15'd0, r_stride};
                mul_hi = 1'b1;
                mul_clr = 1'b0;
            end
            OP_EDL: begin
                mul_a = r_diff[31:0];
                mul_b = ratio_sel;
            end
            OP_EDH: begin
                mul_a = r_diff[63:32];
                mul_b = ratio_sel;
                mul_hi = 1'b1;
                mul_clr = 1'b0;
            end
            default: mul_en = 1'b0;
        endcase
        prod     = {22'd0, mul_a} * {32'd0, mul_b};
        acc_base = mul_clr ? 64'd0 : r_acc;
        acc_add  = mul_hi ? {prod[31:0], 32'd0} : {10'd0, prod};
    end

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_acc <= acc_base + acc_add;
        end
    end

    // Rounding of the two exp product stages
    logic [63:0] t1_rnd, e_rnd;
    logic [27:0] e_val;

    assign t1_rnd = r_acc + 64'd32768;
    assign e_rnd  = r_acc + 64'd8388608;
    assign e_val  = e_rnd[51:24];

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_tmp) begin
            r_tmp <= t1_rnd[51:16];
        end
    end

    // Saturating bin sums, cleared by bin zero
    logic [31:0] s_base;
    logic [35:0] w_base;
    logic [32:0] s_new;
    logic [31:0] w_term;
    logic [36:0] w_new;

    always_comb begin
        s_base = (r_bin == 4'd0) ? 32'd0 : r_esum[i_cmd.side];
        w_base = (r_bin == 4'd0) ? 36'd0 : r_wsum[i_cmd.side];
        s_new  = {1'b0, s_base} + {5'd0, e_val};
        w_term = {28'd0, r_bin} * {4'd0, e_val};
        w_new  = {1'b0, w_base} + {5'd0, w_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_esum[k] <= '0;
                r_wsum[k] <= '0;
            end
        end else if (i_cmd.acc_sum) begin
            r_esum[i_cmd.side] <= s_new[32] ? 32'hFFFF_FFFF : s_new[31:0];
            r_wsum[i_cmd.side] <= w_new[36] ? 36'hF_FFFF_FFFF : w_new[35:0];
        end
    end

    // Restoring divider, one quotient bit a cycle
    logic [NUM_W-1:0] r_num, r_quo;
    logic [31:0]      r_rem, r_den;
    logic [32:0]      rem_sh, rem_sub;
    logic             q_bit;

    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, r_den};
    assign q_bit   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_conf) begin
            r_num <= NUM_W'({e_val, 16'd0});
            r_den <= {4'd0, e_val} + 32'd65536;
            r_rem <= '0;
        end else if (i_cmd.div_dist) begin
            r_num <= {r_acc[NUM_W-9:0], 8'd0};
            r_den <= r_esum[i_cmd.side];
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
            r_rem <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
        end
    end

    assign o_status.conf_pass = (r_quo[15:0] > r_thr);

    // Confidence and cell centre, Q.8 pixels
    logic [15:0] r_conf;
    logic [22:0] r_cx, r_cy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_conf) begin
            r_conf <= r_quo[15:0];
            r_cx   <= 23'({7'd0, r_col, 8'h80} * {16'd0, r_stride});
            r_cy   <= 23'({7'd0, r_row, 8'h80} * {16'd0, r_stride});
        end
    end

    // Edge offset before scaling: centre -/+ distance - padding
    logic [NUM_W-1:0] side_dist;
    logic [63:0]      c64, d64, p64;

    always_comb begin
        side_dist = (r_den == 32'd0) ? '0 : r_quo;
        c64  = {41'd0, i_cmd.side[0] ? r_cy : r_cx};
        d64  = {{(64-NUM_W){1'b0}}, side_dist};
        p64  = {46'd0, i_cmd.side[0] ? r_pad_top : r_pad_left, 8'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.make_diff) begin
            r_diff <= i_cmd.side[1] ? $signed(c64 + d64 - p64) : $signed(c64 - d64 - p64);
        end
    end

    // Clip scaled edges: near edges at zero, far edges at size minus one
    logic signed [63:0] r_edge [4];
    logic signed [63:0] v_edge, lim_m1, lim;

    always_comb begin
        v_edge = $signed(r_acc);
        lim_m1 = $signed({49'd0, i_cmd.side[0] ? r_img_h : r_img_w}) - 64'sd1;
        lim    = $signed({lim_m1[39:0], 24'd0});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_edge) begin
            if (!i_cmd.side[1]) begin
                r_edge[i_cmd.side] <= (v_edge < 0) ? 64'sd0 : v_edge;
            end else begin
                r_edge[i_cmd.side] <= (v_edge > lim) ? lim : v_edge;
            end
        end
    end

    // Q.24 to whole pixels, saturated to the field
    function automatic logic [13:0] to_pix(input logic signed [63:0] v);
        logic [13:0] p;
        if (v <= 0) begin
            p = 14'd0;
        end else if (v[63:24] > 40'd16383) begin
            p = 14'd16383;
        end else begin
            p = v[37:24];
        end
        return p;
    endfunction

    function automatic logic [7:0] cell_pos(input logic [7:0] c);
        logic [7:0] r;
        if ({24'd0, c} >= 32'(GRID_MAX)) begin
            r = 8'(GRID_MAX - 1);
        end else begin
            r = c;
        end
        return r;
    endfunction

    logic signed [63:0] w_q24, h_q24;

    assign w_q24 = r_edge[2] - r_edge[0];
    assign h_q24 = r_edge[3] - r_edge[1];

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_box_x      <= to_pix(r_edge[0]);
            o_box_y      <= to_pix(r_edge[1]);
            o_box_width  <= to_pix(w_q24);
            o_box_height <= to_pix(h_q24);
            o_confidence <= r_conf;
            o_box_row    <= cell_pos(r_row);
            o_box_col    <= cell_pos(r_col);
        end
    end

endmodule

`default_nettype wire

/* rtl/dfl_box_decoder_unit.sv */
// ----------------------------------------------------------------------------
// dfl_box_decoder_unit
// DFL box decoder: one bin item per transaction, one box per passing cell.
// ----------------------------------------------------------------------------
// Each bin item runs four 6-step exp passes on one shared 32x22 multiplier.
// The last bin adds a class exp, a 51-step divide for the confidence and,
// when it passes, four side passes, each with a 51-step divide, for the box.
// A new item is taken only once the last one is finished: o_stall stays high
// until the controller is back in idle, also for the last bin of a cell.
// Reset: synchronous active low; clears sums and controller, sets config defaults.
`default_nettype none

module dfl_box_decoder_unit
    import dflbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [7:0]           i_cell_row,
    input  wire logic [7:0]           i_cell_col,
    input  wire logic [3:0]           i_bin_index,
    input  wire logic signed [15:0]   i_class_logit,
    input  wire logic signed [15:0]   i_logit_left,
    input  wire logic signed [15:0]   i_logit_top,
    input  wire logic signed [15:0]   i_logit_right,
    input  wire logic signed [15:0]   i_logit_bottom,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic [13:0]               o_box_x,
    output logic [13:0]               o_box_y,
    output logic [13:0]               o_box_width,
    output logic [13:0]               o_box_height,
    output logic [15:0]               o_confidence,
    output logic [7:0]                o_box_row,
    output logic [7:0]                o_box_col,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dflbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    dflbd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_bin_index    (i_bin_index),
        .i_class_logit  (i_class_logit),
        .i_logit_left   (i_logit_left),
        .i_logit_top    (i_logit_top),
        .i_logit_right  (i_logit_right),
        .i_logit_bottom (i_logit_bottom),
        .o_box_x        (o_box_x),
        .o_box_y        (o_box_y),
        .o_box_width    (o_box_width),
        .o_box_height   (o_box_height),
        .o_confidence   (o_confidence),
        .o_box_row      (o_box_row),
        .o_box_col      (o_box_col)
    );

endmodule

`default_nettype wire
